>>> design/rme_pkg.sv
// Shared types and constants of the register machine execute block.
package rme_pkg;

    localparam int OP_W    = 4;
    localparam int BANK_W  = 3;
    localparam int INDEX_W = 9;
    localparam int DATA_W  = 32;
    localparam int PTR_W   = 9;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_DEC   = 4'd3,
        OP_DEC0  = 4'd4,
        OP_INC   = 4'd5,
        OP_INC0  = 4'd6,
        OP_JUMP  = 4'd7,
        OP_JUMP0 = 4'd8,
        OP_RET   = 4'd9,
        OP_RET0  = 4'd10
    } op_t;

    localparam logic [BANK_W-1:0] BANK_DATA    = 3'd0;
    localparam logic [BANK_W-1:0] BANK_STACK   = 3'd1;
    localparam logic [BANK_W-1:0] BANK_HEAP    = 3'd2;
    localparam logic [BANK_W-1:0] BANK_PROGRAM = 3'd3;

    localparam logic [PTR_W-1:0] PTR_RESET = 9'd1;

    typedef enum logic {
        PH_CLEAR,
        PH_RUN
    } phase_t;

endpackage

>>> design/rme_in_if.sv
// Request channel carrying one instruction.
interface rme_in_if import rme_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [BANK_W-1:0]  first_bank;
    logic [INDEX_W-1:0] first_index;
    logic [BANK_W-1:0]  second_bank;
    logic [INDEX_W-1:0] second_index;

    modport source (
        output valid, operation, first_bank, first_index, second_bank, second_index,
        input  ready
    );
    modport sink (
        input  valid, operation, first_bank, first_index, second_bank, second_index,
        output ready
    );
endinterface

>>> design/rme_out_if.sv
// Result channel carrying the outcome of one instruction.
interface rme_out_if import rme_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     status;
    logic                     return_valid;
    logic signed [DATA_W-1:0] returned_value;
    logic [PTR_W-1:0]         next_pointer;

    modport source (
        output valid, status, return_valid, returned_value, next_pointer,
        input  ready
    );
    modport sink (
        input  valid, status, return_valid, returned_value, next_pointer,
        output ready
    );
endinterface

>>> design/rme_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/register_machine_execute.sv
// Top level of the register machine execute block.
//
// The instr channel takes one instruction per request: an opcode and two
// operand references (bank and one-based register number). The result
// channel returns one item per instruction: the error status, the returned
// value with its valid flag, and the program line to execute next.
// The data, stack and heap banks share one register memory, kept as two
// copies so that both operands are read in the same cycle; every write goes
// to both copies.
// The pipeline has two stages: the memory read, then execute and write-back
// into the output register. One instruction can be accepted every cycle while
// the result channel does not stall. A write from the previous instruction is
// forwarded to the next one.
// After reset a clearing pass writes zero to every memory entry, all
// 3 * 2**ceil(log2(BANK_DEPTH)) of them (768 at the default depth); instr.ready
// stays low during that pass. The program pointer resets to one.
// When the receiver stalls, the finished result waits in the output register,
// one more instruction waits in the execute stage, and then instr.ready drops.
module register_machine_execute import rme_pkg::*; #(
    parameter int BANK_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    rme_in_if.sink     instr,
    rme_out_if.source  result
);

    localparam int AW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int MEM_DEPTH = 3 << AW;
    localparam int MAW       = AW + 2;

    function automatic logic index_ok(input logic [INDEX_W-1:0] idx);
        return (idx != '0) && (32'(idx) <= 32'(BANK_DEPTH));
    endfunction

    function automatic logic [MAW-1:0] mem_addr(input logic [BANK_W-1:0] bank,
                                                 input logic [INDEX_W-1:0] idx);
        logic [31:0] idx_m1;
        logic [1:0]  sel;
        idx_m1 = 32'(idx) - 32'd1;
        sel    = (bank < BANK_PROGRAM) ? bank[1:0] : 2'd0;
        return {sel, idx_m1[AW-1:0]};
    endfunction

    // Clearing pass
    phase_t         phase_reg, phase_next;
    logic [MAW-1:0] clr_addr_reg, clr_addr_next;

    // Execute stage
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [BANK_W-1:0]  s1_b1_reg, s1_b2_reg;
    logic [INDEX_W-1:0] s1_i1_reg;
    logic [INDEX_W-1:0] s1_i2_reg;
    logic [MAW-1:0]     s1_a1_reg, s1_a2_reg;
    logic [PTR_W-1:0]   ptr_reg;

    // Most recent write, for forwarding
    logic              lw_valid_reg;
    logic [MAW-1:0]    lw_addr_reg;
    logic [DATA_W-1:0] lw_data_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_status_reg;
    logic              out_ret_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic [PTR_W-1:0]  out_ptr_reg;

    logic              in_fire, s1_adv;
    logic [DATA_W-1:0] rd_a, rd_b;
    logic              mem_we;
    logic [MAW-1:0]    mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    logic              ex_err, ex_wr, ex_jump, ex_ret;
    logic [DATA_W-1:0] ex_wval, ex_rval;
    logic [DATA_W-1:0] v1, v2;
    logic              b1_reg_bank, b2_reg_bank, i1_ok, i2_ok;
    logic              rd1_err, rd2_err, wr1_err, cond_zero;
    logic [PTR_W-1:0]  ptr_next;
    logic              ret_ok;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign instr.ready = (phase_reg == PH_RUN) && (!s1_valid_reg || s1_adv);
    assign in_fire     = instr.valid && instr.ready;

    always_comb
    begin
        phase_next    = phase_reg;
        clr_addr_next = clr_addr_reg;
        case (phase_reg)
            PH_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + MAW'(1);
                if (clr_addr_reg == MAW'(MEM_DEPTH - 1))
                begin
                    phase_next = PH_RUN;
                end
            end
            PH_RUN:
            begin
                clr_addr_next = clr_addr_reg;
            end
            default:
            begin
                phase_next = PH_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign mem_we    = (phase_reg == PH_CLEAR) || (s1_adv && ex_wr && !ex_err);
    assign mem_waddr = (phase_reg == PH_CLEAR) ? clr_addr_reg : s1_a1_reg;
    assign mem_wdata = (phase_reg == PH_CLEAR) ? '0 : ex_wval;

    rme_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram_first (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_fire),
        .raddr (mem_addr(instr.first_bank, instr.first_index)),
        .rdata (rd_a)
    );

    rme_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram_second (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (in_fire),
        .raddr (mem_addr(instr.second_bank, instr.second_index)),
        .rdata (rd_b)
    );

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg <= op_t'(instr.operation);
            s1_b1_reg <= instr.first_bank;
            s1_i1_reg <= instr.first_index;
            s1_b2_reg <= instr.second_bank;
            s1_i2_reg <= instr.second_index;
            s1_a1_reg <= mem_addr(instr.first_bank, instr.first_index);
            s1_a2_reg <= mem_addr(instr.second_bank, instr.second_index);
        end
    end

    // Operand values; a read outside the three register banks gives zero.
    always_comb
    begin
        b1_reg_bank = s1_b1_reg < BANK_PROGRAM;
        b2_reg_bank = s1_b2_reg < BANK_PROGRAM;
        i1_ok       = index_ok(s1_i1_reg);
        i2_ok       = index_ok(s1_i2_reg);
        v1 = (lw_valid_reg && lw_addr_reg == s1_a1_reg) ? lw_data_reg : rd_a;
        v2 = (lw_valid_reg && lw_addr_reg == s1_a2_reg) ? lw_data_reg : rd_b;
        if (!(b1_reg_bank && i1_ok))
        begin
            v1 = '0;
        end
        if (!(b2_reg_bank && i2_ok))
        begin
            v2 = '0;
        end
        rd1_err   = b1_reg_bank && !i1_ok;
        rd2_err   = b2_reg_bank && !i2_ok;
        wr1_err   = !(b1_reg_bank && i1_ok);
        cond_zero = (v2 == '0);
    end

    always_comb
    begin
        ex_err  = 1'b0;
        ex_wr   = 1'b0;
        ex_jump = 1'b0;
        ex_ret  = 1'b0;
        ex_wval = '0;
        ex_rval = '0;
        case (s1_op_reg)
            OP_INIT:
            begin
                ex_err = wr1_err;
                ex_wr  = 1'b1;
            end
            OP_ADD:
            begin
                ex_err  = rd1_err || rd2_err || wr1_err;
                ex_wr   = 1'b1;
                ex_wval = v1 + v2;
            end
            OP_SUB:
            begin
                ex_err  = rd1_err || rd2_err || wr1_err;
                ex_wr   = 1'b1;
                ex_wval = v1 - v2;
            end
            OP_DEC:
            begin
                ex_err  = rd1_err || wr1_err;
                ex_wr   = 1'b1;
                ex_wval = v1 - DATA_W'(1);
            end
            OP_INC:
            begin
                ex_err  = rd1_err || wr1_err;
                ex_wr   = 1'b1;
                ex_wval = v1 + DATA_W'(1);
            end
            OP_DEC0:
            begin
                ex_err  = rd1_err || rd2_err || (cond_zero && wr1_err);
                ex_wr   = cond_zero;
                ex_wval = v1 - DATA_W'(1);
            end
            OP_INC0:
            begin
                ex_err  = rd1_err || rd2_err || (cond_zero && wr1_err);
                ex_wr   = cond_zero;
                ex_wval = v1 + DATA_W'(1);
            end
            OP_JUMP:
            begin
                ex_err  = s1_b1_reg != BANK_PROGRAM;
                ex_jump = 1'b1;
            end
            OP_JUMP0:
            begin
                ex_err  = rd2_err || (cond_zero && s1_b1_reg != BANK_PROGRAM);
                ex_jump = cond_zero;
            end
            OP_RET:
            begin
                ex_err  = rd1_err;
                ex_ret  = 1'b1;
                ex_rval = v1;
            end
            OP_RET0:
            begin
                ex_err  = rd1_err || rd2_err || !cond_zero;
                ex_ret  = 1'b1;
                ex_rval = v1;
            end
            default:
            begin
                ex_err = 1'b1;
            end
        endcase
        ret_ok   = ex_ret && !ex_err;
        ptr_next = (ex_jump && !ex_err) ? s1_i1_reg : ptr_reg + PTR_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            ptr_reg       <= PTR_RESET;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                ptr_reg       <= ptr_next;
                out_valid_reg <= 1'b1;
                if (ex_wr && !ex_err)
                begin
                    lw_valid_reg <= 1'b1;
                end
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_status_reg <= ex_err;
            out_ret_reg    <= ret_ok;
            out_value_reg  <= ret_ok ? ex_rval : '0;
            out_ptr_reg    <= ptr_next;
            if (ex_wr && !ex_err)
            begin
                lw_addr_reg <= s1_a1_reg;
                lw_data_reg <= ex_wval;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = out_status_reg;
    assign result.return_valid   = out_ret_reg;
    assign result.returned_value = $signed(out_value_reg);
    assign result.next_pointer   = out_ptr_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (instr.valid && instr.ready) |-> (phase_reg == PH_RUN))
        else $error("instruction accepted during the clearing pass");

    a_return_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.return_valid) |-> !result.status)
        else $error("returned value delivered together with an error");

    a_no_return_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.return_valid) |-> (result.returned_value == '0))
        else $error("nonzero returned value without a return");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=>
            (s1_valid_reg && $stable(s1_a1_reg) && $stable(s1_a2_reg)))
        else $error("stalled instruction in the execute stage was lost");

endmodule

>>> test/register_machine_execute_checker.sv
// Checker that predicts every instruction outcome and compares it with the result channel.
module rme_execute_checker import rme_pkg::*; #(
    parameter int BANK_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    rme_in_if    instr,
    rme_out_if   result,
    output int   mismatches,
    output int   pending
);

    typedef struct packed {
        logic              status;
        logic              return_valid;
        logic [DATA_W-1:0] returned_value;
        logic [PTR_W-1:0]  next_pointer;
    } exec_outcome_t;

    // Data, stack and heap banks, indexed by bank code and one-based register number.
    logic [DATA_W-1:0] bank_words [0:2][1:BANK_DEPTH];
    logic [PTR_W-1:0]  program_line;
    exec_outcome_t     outcome_queue [$];
    exec_outcome_t     want;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches = mismatches + 1;
    endtask

    function automatic logic is_register_bank(input logic [BANK_W-1:0] bank);
        return bank == BANK_DATA || bank == BANK_STACK || bank == BANK_HEAP;
    endfunction

    function automatic logic index_in_range(input logic [INDEX_W-1:0] idx);
        return idx >= 1 && idx <= BANK_DEPTH;
    endfunction

    // A read of a register bank out of range is an error; other banks read as zero.
    function automatic logic read_fault(input logic [BANK_W-1:0] bank,
                                        input logic [INDEX_W-1:0] idx);
        return is_register_bank(bank) && !index_in_range(idx);
    endfunction

    function automatic logic write_fault(input logic [BANK_W-1:0] bank,
                                         input logic [INDEX_W-1:0] idx);
        return !is_register_bank(bank) || !index_in_range(idx);
    endfunction

    function automatic logic [DATA_W-1:0] fetch(input logic [BANK_W-1:0] bank,
                                                input logic [INDEX_W-1:0] idx);
        if (!is_register_bank(bank) || !index_in_range(idx))
            return '0;
        return bank_words[bank][idx];
    endfunction

    // Executes one instruction on the shadow state and returns its outcome.
    function automatic exec_outcome_t execute(input logic [OP_W-1:0] op,
                                              input logic [BANK_W-1:0] b1,
                                              input logic [INDEX_W-1:0] i1,
                                              input logic [BANK_W-1:0] b2,
                                              input logic [INDEX_W-1:0] i2);
        exec_outcome_t     res;
        logic              fault;
        logic              write_back;
        logic              take_jump;
        logic              deliver;
        logic [DATA_W-1:0] v1;
        logic [DATA_W-1:0] v2;
        logic [DATA_W-1:0] wval;
        logic [DATA_W-1:0] rval;
        logic [PTR_W-1:0]  next;

        fault      = 1'b0;
        write_back = 1'b0;
        take_jump  = 1'b0;
        deliver    = 1'b0;
        wval       = '0;
        rval       = '0;
        v1         = fetch(b1, i1);
        v2         = fetch(b2, i2);
        next       = program_line + PTR_W'(1);

        case (op)
            OP_INIT:
            begin
                fault      = write_fault(b1, i1);
                write_back = 1'b1;
            end
            OP_ADD, OP_SUB:
            begin
                fault      = read_fault(b1, i1) | read_fault(b2, i2) | write_fault(b1, i1);
                write_back = 1'b1;
                wval       = (op == OP_ADD) ? v1 + v2 : v1 - v2;
            end
            OP_DEC, OP_INC:
            begin
                fault      = read_fault(b1, i1) | write_fault(b1, i1);
                write_back = 1'b1;
                wval       = (op == OP_INC) ? v1 + 1 : v1 - 1;
            end
            OP_DEC0, OP_INC0:
            begin
                fault = read_fault(b1, i1) | read_fault(b2, i2);
                if (v2 == 0)
                begin
                    fault      = fault | write_fault(b1, i1);
                    write_back = 1'b1;
                    wval       = (op == OP_INC0) ? v1 + 1 : v1 - 1;
                end
            end
            OP_JUMP:
            begin
                if (b1 == BANK_PROGRAM)
                    take_jump = 1'b1;
                else
                    fault = 1'b1;
            end
            OP_JUMP0:
            begin
                fault = read_fault(b2, i2);
                if (v2 == 0)
                begin
                    if (b1 == BANK_PROGRAM)
                        take_jump = 1'b1;
                    else
                        fault = 1'b1;
                end
            end
            OP_RET:
            begin
                fault   = read_fault(b1, i1);
                rval    = v1;
                deliver = 1'b1;
            end
            OP_RET0:
            begin
                fault = read_fault(b1, i1) | read_fault(b2, i2);
                rval  = v1;
                if (v2 == 0)
                    deliver = 1'b1;
                else
                    fault = 1'b1;
            end
            default:
                fault = 1'b1;
        endcase

        // An error suppresses the write and the jump, but the pointer still advances.
        if (!fault)
        begin
            if (write_back)
                bank_words[b1][i1] = wval;
            if (take_jump)
                next = i1;
        end
        if (fault || !deliver)
        begin
            deliver = 1'b0;
            rval    = '0;
        end
        program_line = next;

        res.status         = fault;
        res.return_valid   = deliver;
        res.returned_value = rval;
        res.next_pointer   = next;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < 3; b++)
                for (int k = 1; k <= BANK_DEPTH; k++)
                    bank_words[b][k] = '0;
            program_line = PTR_RESET;
            outcome_queue.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            // The result side is handled first: a result never belongs to a request
            // accepted at the same edge.
            if (result.valid && result.ready)
            begin
                if (outcome_queue.size() == 0)
                    report_mismatch("result arrived with no instruction outstanding");
                else
                begin
                    want = outcome_queue.pop_front();
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0b, expected %0b",
                                                  result.status, want.status));
                    if (result.return_valid !== want.return_valid)
                        report_mismatch($sformatf("return_valid %0b, expected %0b",
                                                  result.return_valid, want.return_valid));
                    if (result.returned_value !== want.returned_value)
                        report_mismatch($sformatf("returned_value %0h, expected %0h",
                                                  result.returned_value, want.returned_value));
                    if (result.next_pointer !== want.next_pointer)
                        report_mismatch($sformatf("next_pointer %0d, expected %0d",
                                                  result.next_pointer, want.next_pointer));
                end
            end
            if (instr.valid && instr.ready)
                outcome_queue.push_back(execute(instr.operation, instr.first_bank,
                                                instr.first_index, instr.second_bank,
                                                instr.second_index));
            pending = outcome_queue.size();
        end
    end

endmodule

>>> test/register_machine_execute_test.sv
// Top of the register machine execute testbench: clock, reset, stimulus and verdict.
module register_machine_execute_test;
    import rme_pkg::*;

    localparam int                RANDOM_ITEMS = 950;
    localparam int                IDLE_LIMIT   = 5000;
    localparam logic [OP_W-1:0]   OP_BAD_FIRST = 4'd11;
    localparam logic [OP_W-1:0]   OP_BAD_LAST  = 4'd15;
    localparam logic [BANK_W-1:0] BANK_OTHER   = 3'd4;
    localparam logic [BANK_W-1:0] BANK_LAST    = 3'd7;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   mismatches;
    int   pending;
    int   idle_cycles = 0;

    rme_in_if  instr_ch ();
    rme_out_if result_ch ();

    register_machine_execute uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch),
        .result (result_ch)
    );

    rme_execute_checker outcome_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .instr      (instr_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic issue(input logic [OP_W-1:0] op, input logic [BANK_W-1:0] b1,
                         input logic [INDEX_W-1:0] i1, input logic [BANK_W-1:0] b2,
                         input logic [INDEX_W-1:0] i2);
        int gap;
        gap = quiet ? 0 : idle_gap();
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid        <= 1'b1;
        instr_ch.operation    <= op;
        instr_ch.first_bank   <= b1;
        instr_ch.first_index  <= i1;
        instr_ch.second_bank  <= b2;
        instr_ch.second_index <= i2;
        do @(posedge clk); while (!instr_ch.ready);
    endtask

    // Small indexes dominate so that registers are reused and conditions vary.
    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return INDEX_W'($urandom_range(1, 6));
        if (r < 80)
            return INDEX_W'($urandom_range(250, 256));
        if (r < 90)
            return $urandom_range(0, 1) ? 9'd0 : INDEX_W'($urandom_range(257, 511));
        return INDEX_W'($urandom_range(0, 511));
    endfunction

    function automatic logic [BANK_W-1:0] pick_bank();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return BANK_W'($urandom_range(BANK_DATA, BANK_HEAP));
        if (r < 88)
            return BANK_PROGRAM;
        return BANK_W'($urandom_range(BANK_OTHER, BANK_LAST));
    endfunction

    task automatic issue_random();
        logic [OP_W-1:0]    op;
        logic [BANK_W-1:0]  b1;
        logic [INDEX_W-1:0] i1;
        op = ($urandom_range(0, 99) < 92) ? OP_W'($urandom_range(OP_INIT, OP_RET0))
                                          : OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        b1 = pick_bank();
        i1 = pick_index();
        // Jumps mostly target the program bank, anywhere in the line range.
        if (op == OP_JUMP || op == OP_JUMP0)
        begin
            if ($urandom_range(0, 99) < 80)
                b1 = BANK_PROGRAM;
            i1 = INDEX_W'($urandom_range(0, 511));
        end
        issue(op, b1, i1, pick_bank(), pick_index());
    endtask

    initial
    begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            int stall;
            stall = quiet ? 0 : idle_gap();
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        quiet                   = 1'b0;
        rst_n                  <= 1'b0;
        instr_ch.valid         <= 1'b0;
        instr_ch.operation     <= '0;
        instr_ch.first_bank    <= '0;
        instr_ch.first_index   <= '0;
        instr_ch.second_bank   <= '0;
        instr_ch.second_index  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Arithmetic, wrap-around and the conditional forms.
        issue(OP_INIT, BANK_DATA, 9'd1, BANK_DATA, 9'd0);
        issue(OP_INC, BANK_DATA, 9'd1, BANK_DATA, 9'd0);
        issue(OP_INC, BANK_DATA, 9'd1, BANK_DATA, 9'd0);
        issue(OP_ADD, BANK_DATA, 9'd1, BANK_DATA, 9'd1);
        issue(OP_SUB, BANK_STACK, 9'd1, BANK_DATA, 9'd1);
        issue(OP_DEC, BANK_HEAP, 9'd256, BANK_DATA, 9'd1);
        issue(OP_INC, BANK_HEAP, 9'd256, BANK_DATA, 9'd1);
        issue(OP_DEC0, BANK_DATA, 9'd2, BANK_DATA, 9'd3);
        issue(OP_INC0, BANK_STACK, 9'd2, BANK_DATA, 9'd1);
        issue(OP_ADD, BANK_DATA, 9'd1, BANK_LAST, 9'd1);
        // Jumps, including the pointer wrapping past its top line.
        issue(OP_JUMP, BANK_PROGRAM, 9'd511, BANK_DATA, 9'd0);
        issue(OP_INC, BANK_DATA, 9'd5, BANK_DATA, 9'd0);
        issue(OP_JUMP0, BANK_PROGRAM, 9'd5, BANK_HEAP, 9'd1);
        issue(OP_JUMP0, BANK_DATA, 9'd5, BANK_HEAP, 9'd1);
        issue(OP_JUMP0, BANK_DATA, 9'd5, BANK_DATA, 9'd1);
        issue(OP_JUMP, BANK_STACK, 9'd3, BANK_DATA, 9'd1);
        // Returns, reads from non-register banks and index range errors.
        issue(OP_RET, BANK_STACK, 9'd1, BANK_DATA, 9'd0);
        issue(OP_RET0, BANK_DATA, 9'd1, BANK_HEAP, 9'd2);
        issue(OP_RET0, BANK_DATA, 9'd1, BANK_DATA, 9'd1);
        issue(OP_RET, BANK_PROGRAM, 9'd7, BANK_DATA, 9'd0);
        issue(OP_RET, BANK_DATA, 9'd0, BANK_DATA, 9'd1);
        issue(OP_RET, BANK_DATA, 9'd257, BANK_DATA, 9'd1);
        issue(OP_SUB, BANK_DATA, 9'd1, BANK_DATA, 9'd0);
        // Writes to banks that cannot be written, and invalid opcodes.
        issue(OP_INIT, BANK_PROGRAM, 9'd1, BANK_DATA, 9'd0);
        issue(OP_INIT, BANK_OTHER, 9'd1, BANK_DATA, 9'd0);
        issue(OP_ADD, BANK_DATA, 9'd300, BANK_DATA, 9'd1);
        issue(OP_BAD_FIRST, BANK_DATA, 9'd1, BANK_DATA, 9'd1);
        issue(OP_BAD_LAST, BANK_LAST, 9'd511, BANK_LAST, 9'd511);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 400 && n < 500);
            issue_random();
        end
        quiet = 1'b0;
        instr_ch.valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
